FILE: src/chained_range_remap_min_defines.svh
// Assertion helpers shared by the checker files.
`ifndef CHAINED_RANGE_REMAP_MIN_DEFINES_SVH
`define CHAINED_RANGE_REMAP_MIN_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define CRRM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off while in reset.
`define CRRM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that is also checked through reset.
`define CRRM_ASSERT_NXT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

FILE: src/crrm_pkg.sv
// ----------------------------------------------------------------------------
// crrm_pkg
// Request codes, controller states and walk control for the range remap.
// ----------------------------------------------------------------------------
`default_nettype none

package crrm_pkg;

  localparam logic [1:0] REQ_WRITE     = 2'd0;
  localparam logic [1:0] REQ_TRANSLATE = 2'd1;
  localparam logic [1:0] REQ_RESTART   = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } crrm_state_t;

  typedef struct packed {
    logic start;      // new key loaded
    logic cmp_en;     // window data valid this cycle
    logic stage_end;  // window is the last of its stage
  } crrm_walk_ctrl_t;

endpackage

`default_nettype wire

FILE: src/chained_range_remap_min.sv
// ----------------------------------------------------------------------------
// chained_range_remap_min
// Multi-stage range remap with a running minimum of the remapped keys.
// ----------------------------------------------------------------------------
// A translate item walks every stored window in order, one RAM read per cycle
// (448 reads at the defaults), before its result lands in the output register.
// After reset the block clears all STAGES*ENTRIES entries of the valid RAM,
// one entry per cycle, with in_stall held high.
`default_nettype none

module chained_range_remap_min #(
  parameter int STAGES     = 7,
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [2:0]            in_stage_sel,
  input  wire logic [5:0]            in_slot_sel,
  input  wire logic                  in_window_enable,
  input  wire logic [VALUE_BITS-1:0] in_dest_base,
  input  wire logic [VALUE_BITS-1:0] in_source_base,
  input  wire logic [VALUE_BITS-1:0] in_window_length,
  input  wire logic [VALUE_BITS:0]   in_key_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VALUE_BITS:0]        out_final_value,
  output logic [VALUE_BITS:0]        out_lowest_value,
  output logic                       out_overlap_seen
);

  localparam int SLOTS  = STAGES * ENTRIES;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DATA_W = 3 * VALUE_BITS;

  crrm_pkg::crrm_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_r;
  logic [ADDR_W-1:0] idx_r;
  logic [SLOT_W-1:0] slot_r;
  logic              issue_done_r;
  logic              pend_r, pend_end_r, pend_last_r;
  logic [VALUE_BITS:0] low_r;
  logic                out_valid_r;
  logic [VALUE_BITS:0] out_final_r, out_low_r;
  logic                out_ovl_r;

  logic in_acc, wr_ok, issue, clear_en, load_out;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] vld_waddr;
  logic              vld_we, vld_wdata, dat_we;
  logic              rd_vld;
  logic [DATA_W-1:0] rd_data;
  logic [VALUE_BITS:0] key_out, low_cand;
  logic                overlap;
  crrm_pkg::crrm_walk_ctrl_t wctrl;

  assign in_acc  = in_valid && !in_stall;
  assign wr_addr = ADDR_W'(int'(in_stage_sel) * ENTRIES + int'(in_slot_sel));
  assign wr_ok   = in_acc && (in_req_type == crrm_pkg::REQ_WRITE) &&
                   (int'(in_stage_sel) < STAGES) && (int'(in_slot_sel) < ENTRIES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crrm_pkg::ST_CLEAR: begin
        if (clr_r == ADDR_W'(SLOTS - 1)) state_nxt = crrm_pkg::ST_IDLE;
      end
      crrm_pkg::ST_IDLE: begin
        if (in_acc && in_req_type == crrm_pkg::REQ_TRANSLATE) state_nxt = crrm_pkg::ST_WALK;
      end
      crrm_pkg::ST_WALK: begin
        if (pend_r && pend_last_r) state_nxt = crrm_pkg::ST_DONE;
      end
      crrm_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = crrm_pkg::ST_IDLE;
      end
      default: state_nxt = crrm_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    clear_en = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      crrm_pkg::ST_CLEAR: clear_en = 1'b1;
      crrm_pkg::ST_IDLE:  in_stall = 1'b0;
      crrm_pkg::ST_WALK:  issue = !issue_done_r;
      crrm_pkg::ST_DONE:  load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    wctrl.start     = in_acc && (in_req_type == crrm_pkg::REQ_TRANSLATE);
    wctrl.cmp_en    = pend_r;
    wctrl.stage_end = pend_end_r;
  end

  assign vld_we    = clear_en || wr_ok;
  assign vld_waddr = clear_en ? clr_r : wr_addr;
  assign vld_wdata = clear_en ? 1'b0 : in_window_enable;
  assign dat_we    = wr_ok && in_window_enable;

  assign low_cand = (key_out < low_r) ? key_out : low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= crrm_pkg::ST_CLEAR;
      clr_r        <= '0;
      idx_r        <= '0;
      slot_r       <= '0;
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      low_r        <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clear_en) clr_r <= clr_r + 1'b1;
      pend_r      <= issue;
      pend_end_r  <= (slot_r == SLOT_W'(ENTRIES - 1));
      pend_last_r <= (idx_r == ADDR_W'(SLOTS - 1));
      if (wctrl.start) begin
        idx_r        <= '0;
        slot_r       <= '0;
        issue_done_r <= 1'b0;
      end else if (issue) begin
        if (idx_r == ADDR_W'(SLOTS - 1)) issue_done_r <= 1'b1;
        else idx_r <= idx_r + 1'b1;
        if (slot_r == SLOT_W'(ENTRIES - 1)) slot_r <= '0;
        else slot_r <= slot_r + 1'b1;
      end
      if (in_acc && in_req_type == crrm_pkg::REQ_RESTART) begin
        low_r <= '1;
      end else if (load_out) begin
        low_r <= low_cand;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_final_r <= key_out;
      out_low_r   <= low_cand;
      out_ovl_r   <= overlap;
    end
  end

  crrm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (idx_r),
    .rdata (rd_vld)
  );

  crrm_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (wr_addr),
    .wdata ({in_dest_base, in_source_base, in_window_length}),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  crrm_walk #(.VALUE_BITS(VALUE_BITS)) u_walk (
    .clk         (clk),
    .ctrl        (wctrl),
    .key_in      (in_key_value),
    .win_valid   (rd_vld),
    .win_dest    (rd_data[DATA_W-1 -: VALUE_BITS]),
    .win_source  (rd_data[2*VALUE_BITS-1 -: VALUE_BITS]),
    .win_len     (rd_data[VALUE_BITS-1:0]),
    .key_out     (key_out),
    .overlap_out (overlap)
  );

  assign out_valid        = out_valid_r;
  assign out_final_value  = out_final_r;
  assign out_lowest_value = out_low_r;
  assign out_overlap_seen = out_ovl_r;

endmodule

`default_nettype wire

FILE: src/crrm_ram.sv
// ----------------------------------------------------------------------------
// crrm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/crrm_walk.sv
// ----------------------------------------------------------------------------
// crrm_walk
// Window match datapath: checks one stored window per cycle against the key
// that entered the current stage, and commits the stage result at stage end.
// ----------------------------------------------------------------------------
`default_nettype none

module crrm_walk #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                      clk,
  input  wire crrm_pkg::crrm_walk_ctrl_t ctrl,
  input  wire logic [VALUE_BITS:0]       key_in,
  input  wire logic                      win_valid,
  input  wire logic [VALUE_BITS-1:0]     win_dest,
  input  wire logic [VALUE_BITS-1:0]     win_source,
  input  wire logic [VALUE_BITS-1:0]     win_len,
  output logic      [VALUE_BITS:0]       key_out,
  output logic                           overlap_out
);

  logic [VALUE_BITS:0] key_r, key_nxt;
  logic [VALUE_BITS:0] res_r, res_nxt;
  logic                hit_r, hit_nxt;
  logic                ovl_r, ovl_nxt;

  logic [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0] mapped;
  logic                match;

  always_comb begin
    diff   = key_r - {1'b0, win_source};
    mapped = {1'b0, win_dest} + diff;
    match  = win_valid && (key_r >= {1'b0, win_source}) && (diff < {1'b0, win_len});
  end

  always_comb begin
    key_nxt = key_r;
    res_nxt = res_r;
    hit_nxt = hit_r;
    ovl_nxt = ovl_r;
    if (ctrl.start) begin
      key_nxt = key_in;
      hit_nxt = 1'b0;
      ovl_nxt = 1'b0;
    end else if (ctrl.cmp_en) begin
      // lowest slot wins; later hits only flag the overlap
      if (match && hit_r) begin
        ovl_nxt = 1'b1;
      end else if (match) begin
        hit_nxt = 1'b1;
        res_nxt = mapped;
      end
      if (ctrl.stage_end) begin
        if (hit_nxt) begin
          key_nxt = res_nxt;
        end
        hit_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
    hit_r <= hit_nxt;
    ovl_r <= ovl_nxt;
  end

  assign key_out     = key_r;
  assign overlap_out = ovl_r;

endmodule

`default_nettype wire

FILE: src/crrm_checker.sv
// ----------------------------------------------------------------------------
// crrm_checker
// Port-level checks for the range remap, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chained_range_remap_min_defines.svh"

module crrm_checker #(
  parameter int VALUE_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [1:0]            in_req_type,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [VALUE_BITS:0]   out_final_value,
  input wire logic [VALUE_BITS:0]   out_lowest_value
);

  // a stalled result item holds
  `CRRM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_final_value))

  // the reported minimum never exceeds the item it came with
  `CRRM_ASSERT_IMP(a_low_le_final, out_valid, out_lowest_value <= out_final_value)

  // a translate item occupies the block for the whole walk
  `CRRM_ASSERT_NXT(a_walk_busy, in_valid && !in_stall && in_req_type == crrm_pkg::REQ_TRANSLATE,
                   in_stall)

  // clearing pass follows reset
  `CRRM_ASSERT_NXT_RST(a_clear_after_reset, !rst_n, in_stall)

endmodule

bind chained_range_remap_min crrm_checker #(.VALUE_BITS(VALUE_BITS)) u_crrm_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Chained range remap: window loads, key translation and running minimum are
// driven through the valid/stall channels. A local window table and minimum
// predict each translate result, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NSTG = 7;
  localparam int NSLOT = 64;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int N_RAND = 1310;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [32:0] KEY_ALL = {33{1'b1}};

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  stage;
    logic [5:0]  slot;
    logic        en;
    logic [31:0] dst;
    logic [31:0] src;
    logic [31:0] len;
    logic [32:0] key;
    bit          hold;   // wait for all results before sending
    bit          calm;   // no idling from here on
  } remap_item_t;

  typedef struct {
    logic [32:0] final_v;
    logic [32:0] lowest_v;
    logic        overlap;
  } remap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_stage_sel = '0;
  logic [5:0] in_slot_sel = '0;
  logic in_window_enable = 1'b0;
  logic [31:0] in_dest_base = '0;
  logic [31:0] in_source_base = '0;
  logic [31:0] in_window_length = '0;
  logic [32:0] in_key_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [32:0] out_final_value;
  logic [32:0] out_lowest_value;
  logic out_overlap_seen;

  chained_range_remap_min u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_stage_sel(in_stage_sel),
    .in_slot_sel(in_slot_sel), .in_window_enable(in_window_enable),
    .in_dest_base(in_dest_base), .in_source_base(in_source_base),
    .in_window_length(in_window_length), .in_key_value(in_key_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_final_value(out_final_value), .out_lowest_value(out_lowest_value),
    .out_overlap_seen(out_overlap_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted window table and minimum
  bit          tbl_ok  [NSTG][NSLOT];
  logic [31:0] tbl_dst [NSTG][NSLOT];
  logic [31:0] tbl_src [NSTG][NSLOT];
  logic [31:0] tbl_len [NSTG][NSLOT];
  logic [32:0] low_seen = KEY_ALL;

  remap_item_t   stim_q[$];
  remap_result_t want_q[$];
  remap_item_t   cur;
  int errors = 0;
  int mism = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cnt = 0;
  bit quiet = 0;

  function automatic remap_result_t translate_key(logic [32:0] key_in);
    remap_result_t r;
    longint unsigned k, off;
    bit hit;
    k = key_in;
    r.overlap = 1'b0;
    for (int s = 0; s < NSTG; s++) begin
      hit = 0;
      off = 0;
      for (int w = 0; w < NSLOT; w++) begin
        if (tbl_ok[s][w] && k >= tbl_src[s][w] && k - tbl_src[s][w] < tbl_len[s][w]) begin
          if (hit) r.overlap = 1'b1;
          else begin
            hit = 1;
            off = (tbl_dst[s][w] + (k - tbl_src[s][w])) & 64'h1_FFFF_FFFF;
          end
        end
      end
      if (hit) k = off;
    end
    r.final_v = k[32:0];
    return r;
  endfunction

  function automatic void apply_item(remap_item_t it);
    remap_result_t r;
    case (it.req)
      crrm_pkg::REQ_WRITE: begin
        if (it.stage < NSTG) begin
          tbl_ok[it.stage][it.slot] = it.en;
          if (it.en) begin
            tbl_dst[it.stage][it.slot] = it.dst;
            tbl_src[it.stage][it.slot] = it.src;
            tbl_len[it.stage][it.slot] = it.len;
          end
        end
      end
      crrm_pkg::REQ_TRANSLATE: begin
        r = translate_key(it.key);
        if (r.final_v < low_seen) low_seen = r.final_v;
        r.lowest_v = low_seen;
        want_q = {want_q, r};
      end
      crrm_pkg::REQ_RESTART: low_seen = KEY_ALL;
      default: ;
    endcase
  endfunction

  task automatic push_item(logic [1:0] req, logic [2:0] stg, logic [5:0] slt, logic en,
                           logic [31:0] dst, logic [31:0] src, logic [31:0] len,
                           logic [32:0] key);
    remap_item_t it;
    it.req = req; it.stage = stg; it.slot = slt; it.en = en;
    it.dst = dst; it.src = src; it.len = len; it.key = key;
    it.hold = 0; it.calm = 0;
    stim_q = {stim_q, it};
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) apply_item(cur);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0 &&
                   !(stim_q[0].hold && (in_valid || want_q.size() > 0))) begin
        cur = stim_q.pop_front();
        if (cur.calm) quiet = 1;
        in_req_type <= cur.req;
        in_stage_sel <= cur.stage;
        in_slot_sel <= cur.slot;
        in_window_enable <= cur.en;
        in_dest_base <= cur.dst;
        in_source_base <= cur.src;
        in_window_length <= cur.len;
        in_key_value <= cur.key;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    remap_result_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          errors++;
          if (mism < 10) $display("unexpected result: final %h lowest %h overlap %b",
                                  out_final_value, out_lowest_value, out_overlap_seen);
          mism++;
        end else begin
          w = want_q.pop_front();
          if (w.final_v !== out_final_value || w.lowest_v !== out_lowest_value ||
              w.overlap !== out_overlap_seen) begin
            errors++;
            if (mism < 10)
              $display("mismatch: exp final %h lowest %h ovl %b, got %h %h %b",
                       w.final_v, w.lowest_v, w.overlap,
                       out_final_value, out_lowest_value, out_overlap_seen);
            mism++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  rq;
    logic [31:0] s, l;
    logic [32:0] k;
    int p;
    // directed: chain, zero length, out of range, invalidate, extremes
    push_item(crrm_pkg::REQ_WRITE, 3'd0, 6'd0, 1'b1, 32'd1000, 32'd100, 32'd50, '0);
    push_item(crrm_pkg::REQ_WRITE, 3'd1, 6'd5, 1'b1, 32'd5000, 32'd990, 32'd40, '0);
    push_item(crrm_pkg::REQ_WRITE, 3'd1, 6'd3, 1'b1, 32'd7000, 32'd1010, 32'd10, '0);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'd120);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'd100);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'd150);
    push_item(crrm_pkg::REQ_WRITE, 3'd2, 6'd63, 1'b1, 32'd1, 32'd0, 32'd0, '0);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'd0);
    push_item(crrm_pkg::REQ_WRITE, 3'd7, 6'd0, 1'b1, 32'd9, 32'd0, 32'hFFFF_FFFF, '0);
    push_item(crrm_pkg::REQ_WRITE, 3'd1, 6'd3, 1'b0, '0, '0, '0, '0);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'd120);
    push_item(REQ_UNUSED, 3'd0, 6'd0, 1'b1, '0, '0, '0, 33'd5);
    push_item(crrm_pkg::REQ_RESTART, '0, '0, 1'b0, '0, '0, '0, '0);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, KEY_ALL);
    push_item(crrm_pkg::REQ_WRITE, 3'd6, 6'd10, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, '0);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'h1_FFFF_FFFE);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'h0_FFFF_FFFF);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, KEY_ALL);
    push_item(crrm_pkg::REQ_WRITE, 3'd6, 6'd10, 1'b0, '0, '0, '0, '0);
    push_item(crrm_pkg::REQ_TRANSLATE, '0, '0, 1'b0, '0, '0, '0, 33'd60);
    // random part: windows mostly in a small domain so keys chain through stages
    for (int i = 0; i < N_RAND; i++) begin
      p = $urandom_range(0, 99);
      rq = (p < 55) ? crrm_pkg::REQ_WRITE :
           (p < 94) ? crrm_pkg::REQ_TRANSLATE :
           (p < 98) ? crrm_pkg::REQ_RESTART : REQ_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
        s = $urandom();
        l = $urandom();
        k = {1'($urandom_range(0, 1)), 32'($urandom())};
      end else begin
        s = $urandom_range(0, 4095);
        l = $urandom_range(0, 600);
        k = 33'($urandom_range(0, 4700));
      end
      push_item(rq, ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                6'($urandom_range(0, 63)), ($urandom_range(0, 6) != 0),
                ($urandom_range(0, 9) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 4095)),
                s, l, k);
      if (i == N_RAND / 2) stim_q[stim_q.size() - 1].hold = 1;
      if (i == N_RAND - 120) stim_q[stim_q.size() - 1].calm = 1;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (stim_q.size() > 0 || in_valid || want_q.size() > 0);
    repeat (1000) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: chained_range_remap_min.f
+incdir+src
src/crrm_pkg.sv
src/crrm_ram.sv
src/crrm_walk.sv
src/chained_range_remap_min.sv
src/crrm_checker.sv
tb/sv/tb_top.sv
